// ----- sv/lph_pkg.sv -----
// ----------------------------------------------------------------------------
// Letter position and pair histogram: shared package
// Command codes, field widths, ASCII bounds and the control bundle that the
// top level sends to each count table.
// ----------------------------------------------------------------------------
package lph_pkg;

	// Fixed field widths of the command and result ports.
	localparam int WORD_W  = 40;
	localparam int FIELD_W = 5;
	localparam int COUNT_W = 32;

	// Lowercase letter bounds in ASCII.
	localparam logic [7:0] ASCII_A = 8'h61;
	localparam logic [7:0] ASCII_Z = 8'h7a;

	typedef enum logic [1:0] {
		CMD_CLEAR    = 2'd0,
		CMD_ADD      = 2'd1,
		CMD_RD_POS   = 2'd2,
		CMD_RD_PAIR  = 2'd3
	} cmd_t;

	// At most one member is set in a cycle.
	// rd: plain read, bump: saturating increment, clr: write zero.
	typedef struct packed {
		logic rd;
		logic bump;
		logic clr;
	} tbl_ctl_t;

endpackage

// ----- sv/lph_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port; the read data is registered and returns
// the contents before a write to the same address in the same cycle.
// ----------------------------------------------------------------------------
module lph_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 130,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- sv/lph_table.sv -----
// ----------------------------------------------------------------------------
// Count table
// A RAM with a one-stage read-modify-write path. A bump reads the entry, adds
// one with saturation in the next cycle and writes it back. A write landing in
// the same cycle as a read is forwarded to that read.
// ----------------------------------------------------------------------------
module lph_table #(
	parameter int DEPTH = 130,
	parameter int CNT_W = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  lph_pkg::tbl_ctl_t ctl,
	input  logic [AW-1:0]     addr,
	output logic [CNT_W-1:0]  rdata
);
	import lph_pkg::*;

	logic             bump_s1;
	logic [AW-1:0]    addr_s1;
	logic             wr_valid_q;
	logic [AW-1:0]    wr_addr_q;
	logic [CNT_W-1:0] wr_data_q;

	logic [CNT_W-1:0] ram_rdata;
	logic [CNT_W-1:0] cur;
	logic [CNT_W-1:0] inc;
	logic             we;
	logic [AW-1:0]    waddr;
	logic [CNT_W-1:0] wdata;

	lph_ram #(
		.WIDTH(CNT_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (addr),
		.rdata (ram_rdata)
	);

	// The RAM returns old data when the previous write (a bump or a clear) hit the same
	// entry at the edge that took the read.
	assign cur   = (wr_valid_q && wr_addr_q == addr_s1) ? wr_data_q : ram_rdata;
	assign inc   = (cur == {CNT_W{1'b1}}) ? cur : cur + CNT_W'(1);
	assign rdata = cur;

	assign we    = bump_s1 | ctl.clr;
	assign waddr = bump_s1 ? addr_s1 : addr;
	assign wdata = bump_s1 ? inc : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bump_s1    <= 1'b0;
			wr_valid_q <= 1'b0;
		end else begin
			bump_s1    <= ctl.bump;
			wr_valid_q <= we;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1   <= addr;
		wr_addr_q <= waddr;
		wr_data_q <= wdata;
	end

	a_no_write_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(bump_s1 && ctl.clr))
		else $error("clear write collides with a pending increment");

	a_ctl_single: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.rd, ctl.bump, ctl.clr}))
		else $error("more than one table operation in a cycle");

	a_bump_writes: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.bump |=> (we && waddr == $past(addr)))
		else $error("increment not written back to its entry");

endmodule

// ----- sv/letter_position_and_pair_histogram.sv -----
// ----------------------------------------------------------------------------
// Letter position and pair histogram
// Two saturating count tables, one per (letter, position) and one per ordered
// letter pair, fed by add-word commands and read back one count at a time.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low, and every command
// gives exactly one beat on done, count and bad_query; the receiver cannot
// stall it, so it must take each beat in the cycle it appears. A read has its
// entry registered in the table RAM and then in the result register. An add
// walks every ordered pair of word positions with a counter pair, one pair per
// cycle, so it holds busy through the walk and ST_FIN and gives its result
// once busy is low again; the pair table sees at most one read-modify-write
// per cycle and the positional table is bumped in the same walk. A clear, and
// also reset, sweeps both table memories one entry per cycle, covering
// max(ALPHABET*WORD_LEN, ALPHABET*ALPHABET) entries (676 at the defaults); a
// clear command gives its result when the sweep ends. Busy stays high during
// the sweep after reset, and that sweep gives no result beat. Letters outside
// a to z, and letters whose index is not below ALPHABET, are skipped for both
// tables. Word positions beyond the five bytes of word read as zero bytes.
// ----------------------------------------------------------------------------
module letter_position_and_pair_histogram #(
	parameter int ALPHABET   = 26,
	parameter int WORD_LEN   = 5,
	parameter int COUNT_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   cmd,
	input  logic [lph_pkg::WORD_W-1:0]   word,
	input  logic [lph_pkg::FIELD_W-1:0]  row_letter,
	input  logic [lph_pkg::FIELD_W-1:0]  column,
	output logic                         done,
	output logic [lph_pkg::COUNT_W-1:0]  count,
	output logic                         bad_query
);
	import lph_pkg::*;

	localparam int POS_DEPTH   = ALPHABET * WORD_LEN;
	localparam int PAIR_DEPTH  = ALPHABET * ALPHABET;
	localparam int SWEEP_DEPTH = (POS_DEPTH > PAIR_DEPTH) ? POS_DEPTH : PAIR_DEPTH;
	localparam int POS_AW      = $clog2(POS_DEPTH);
	localparam int PAIR_AW     = $clog2(PAIR_DEPTH);
	localparam int SW          = $clog2(SWEEP_DEPTH);
	localparam int LW          = $clog2(ALPHABET);
	localparam int PW          = $clog2(WORD_LEN);
	localparam int EXT_W       = (WORD_LEN * 8 > WORD_W) ? WORD_LEN * 8 : WORD_W;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_CLEAR = 5'b00010,
		ST_ADD   = 5'b00100,
		ST_FIN   = 5'b01000,
		ST_READ  = 5'b10000
	} state_t;

	state_t              state_q;
	logic [SW-1:0]       sweep_q;
	logic                clr_result_q;
	logic [PW-1:0]       p_q;
	logic [PW-1:0]       q_q;
	logic [WORD_W-1:0]   word_q;
	logic                rd_ok_q;
	logic                rd_pair_q;
	logic                rd_bad_q;
	logic                done_q;
	logic [COUNT_W-1:0]  count_q;
	logic                bad_q;

	// Letter decode of the held word, one lane per position.
	logic [EXT_W-1:0]    word_ext;
	logic [7:0]          byte_v [WORD_LEN];
	logic [7:0]          offs   [WORD_LEN];
	logic                ok     [WORD_LEN];
	logic [LW-1:0]       idx    [WORD_LEN];

	tbl_ctl_t               pos_ctl;
	tbl_ctl_t               pair_ctl;
	logic [POS_AW-1:0]      pos_addr;
	logic [PAIR_AW-1:0]     pair_addr;
	logic [COUNT_BITS-1:0]  pos_rdata;
	logic [COUNT_BITS-1:0]  pair_rdata;

	logic accept;
	logic q_pos_bad;
	logic q_pos_ok;
	logic q_pair_ok;
	logic sweep_last;
	logic add_last;

	assign word_ext = EXT_W'(word_q);

	always_comb begin
		for (int p = 0; p < WORD_LEN; p++) begin
			byte_v[p] = word_ext[p*8 +: 8];
			offs[p]   = byte_v[p] - ASCII_A;
			ok[p]     = (byte_v[p] >= ASCII_A) && (byte_v[p] <= ASCII_Z) &&
				(offs[p] < 8'(ALPHABET));
			idx[p]    = offs[p][LW-1:0];
		end
	end

	assign accept     = start && !busy;
	assign q_pos_bad  = column >= FIELD_W'(WORD_LEN);
	assign q_pos_ok   = !q_pos_bad && (row_letter < FIELD_W'(ALPHABET));
	assign q_pair_ok  = (row_letter < FIELD_W'(ALPHABET)) && (column < FIELD_W'(ALPHABET));
	assign sweep_last = sweep_q == SW'(SWEEP_DEPTH - 1);
	assign add_last   = (p_q == PW'(WORD_LEN - 1)) && (q_q == PW'(WORD_LEN - 1));

	// Table operations issued this cycle.
	always_comb begin
		pos_ctl   = '0;
		pair_ctl  = '0;
		pos_addr  = '0;
		pair_addr = '0;
		unique case (state_q)
			ST_CLEAR: begin
				// The smaller table simply stops being written once its depth is passed.
				pos_ctl.clr  = {1'b0, sweep_q} < (SW + 1)'(POS_DEPTH);
				pair_ctl.clr = {1'b0, sweep_q} < (SW + 1)'(PAIR_DEPTH);
				pos_addr     = sweep_q[POS_AW-1:0];
				pair_addr    = sweep_q[PAIR_AW-1:0];
			end
			ST_ADD: begin
				// Each position is counted once, on the first pass of the inner counter.
				pos_ctl.bump  = (q_q == '0) && ok[p_q];
				pos_addr      = POS_AW'(idx[p_q]) * POS_AW'(WORD_LEN) + POS_AW'(p_q);
				pair_ctl.bump = (p_q != q_q) && ok[p_q] && ok[q_q];
				pair_addr     = PAIR_AW'(idx[p_q]) * PAIR_AW'(ALPHABET) + PAIR_AW'(idx[q_q]);
			end
			ST_IDLE: begin
				if (accept && cmd == CMD_RD_POS && q_pos_ok) begin
					pos_ctl.rd = 1'b1;
				end
				if (accept && cmd == CMD_RD_PAIR && q_pair_ok) begin
					pair_ctl.rd = 1'b1;
				end
				pos_addr  = POS_AW'(row_letter[LW-1:0]) * POS_AW'(WORD_LEN) +
					POS_AW'(column[PW-1:0]);
				pair_addr = PAIR_AW'(row_letter[LW-1:0]) * PAIR_AW'(ALPHABET) +
					PAIR_AW'(column[LW-1:0]);
			end
			default: begin
			end
		endcase
	end

	lph_table #(
		.DEPTH(POS_DEPTH),
		.CNT_W(COUNT_BITS)
	) u_pos_table (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (pos_ctl),
		.addr   (pos_addr),
		.rdata  (pos_rdata)
	);

	lph_table #(
		.DEPTH(PAIR_DEPTH),
		.CNT_W(COUNT_BITS)
	) u_pair_table (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (pair_ctl),
		.addr   (pair_addr),
		.rdata  (pair_rdata)
	);

	// Command sequencer. Reset starts a sweep that clears both tables.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			sweep_q      <= '0;
			clr_result_q <= 1'b0;
			p_q          <= '0;
			q_q          <= '0;
			done_q       <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (cmd_t'(cmd))
							CMD_CLEAR: begin
								state_q      <= ST_CLEAR;
								sweep_q      <= '0;
								clr_result_q <= 1'b1;
							end
							CMD_ADD: begin
								state_q <= ST_ADD;
								p_q     <= '0;
								q_q     <= '0;
							end
							CMD_RD_POS, CMD_RD_PAIR: begin
								state_q <= ST_READ;
							end
							default: begin
							end
						endcase
					end
				end
				ST_CLEAR: begin
					sweep_q <= sweep_q + SW'(1);
					if (sweep_last) begin
						state_q <= ST_IDLE;
						done_q  <= clr_result_q;
					end
				end
				ST_ADD: begin
					if (q_q == PW'(WORD_LEN - 1)) begin
						q_q <= '0;
						p_q <= p_q + PW'(1);
					end else begin
						q_q <= q_q + PW'(1);
					end
					if (add_last) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					// Any increment issued in the final add step is written back in this cycle.
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
				end
				ST_READ: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers of the command and of the result beat.
	always_ff @(posedge clk) begin
		if (accept) begin
			word_q    <= word;
			rd_pair_q <= cmd == CMD_RD_PAIR;
			rd_ok_q   <= (cmd == CMD_RD_PAIR) ? q_pair_ok : q_pos_ok;
			rd_bad_q  <= (cmd == CMD_RD_POS) && q_pos_bad;
		end
		if (state_q == ST_READ) begin
			if (!rd_ok_q) begin
				count_q <= '0;
			end else if (rd_pair_q) begin
				count_q <= COUNT_W'(pair_rdata);
			end else begin
				count_q <= COUNT_W'(pos_rdata);
			end
			bad_q <= rd_bad_q;
		end else begin
			count_q <= '0;
			bad_q   <= 1'b0;
		end
	end

	assign busy      = state_q != ST_IDLE;
	assign done      = done_q;
	assign count     = count_q;
	assign bad_query = bad_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while a command is still running");

	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |=> done)
		else $error("read did not give its result beat");

	a_add_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd == CMD_ADD) |=> (state_q == ST_ADD && p_q == '0 && q_q == '0))
		else $error("add command did not start its pair walk");

	a_add_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADD) |-> !done)
		else $error("result beat during an add");

endmodule

// ----- verif/tb_letter_position_and_pair_histogram.sv -----
// ----------------------------------------------------------------------------
// Letter position and pair histogram: self-checking testbench
// Drives clear, add and read commands into the block, keeps a shadow copy of
// both count tables, and compares every result beat field by field with the
// beat that the shadow tables, or a typed-in expectation, give for its command.
// ----------------------------------------------------------------------------
module tb_letter_position_and_pair_histogram;
	import lph_pkg::*;

	// Table shape at the default parameters of the block.
	localparam int N_LETTERS  = 26;
	localparam int N_POS      = 5;
	localparam int N_RANDOM   = 1900;
	localparam int DRAIN_LIM  = 2000;
	localparam int TAIL_WAIT  = 40;
	localparam int QUIET_LO   = 700;
	localparam int QUIET_HI   = 1000;

	// One command as the sender sees it. When typed is set, the expected
	// count and flag are written into the plan by hand and checked as they
	// stand; otherwise the shadow tables supply them. A set drain bit makes
	// the sender hold off until every outstanding result has come back.
	typedef struct {
		cmd_t               op;
		logic [WORD_W-1:0]  word;
		logic [FIELD_W-1:0] row;
		logic [FIELD_W-1:0] col;
		bit                 typed;
		logic [COUNT_W-1:0] exp_count;
		logic               exp_bad;
		bit                 drain;
	} stim_t;

	// What one result beat should carry.
	typedef struct {
		logic [COUNT_W-1:0] count;
		logic               bad;
	} count_beat_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         cmd;
	logic [WORD_W-1:0]  word;
	logic [FIELD_W-1:0] row_letter;
	logic [FIELD_W-1:0] column;
	logic               done;
	logic [COUNT_W-1:0] count;
	logic               bad_query;

	// Shadow copies of the two count tables, empty as after reset.
	logic [COUNT_W-1:0] letter_at_pos [N_LETTERS][N_POS]     = '{default: '0};
	logic [COUNT_W-1:0] letter_pair   [N_LETTERS][N_LETTERS] = '{default: '0};

	// Results still owed by the block, oldest first.
	count_beat_t awaited_counts[$];
	stim_t       plan[$];

	int mismatches    = 0;
	int beats_checked = 0;
	int nonzero_reads = 0;
	int cmds_sent[4]  = '{0, 0, 0, 0};

	letter_position_and_pair_histogram dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.word       (word),
		.row_letter (row_letter),
		.column     (column),
		.done       (done),
		.count      (count),
		.bad_query  (bad_query)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	task automatic flag_mismatch(input string msg);
		$display("%0t: mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	// Applies one accepted command to the shadow tables and returns the beat
	// the block must answer with. A byte counts as a letter only when it lies
	// in a to z and its index fits the alphabet; anything else is skipped both
	// for the positional count and for every pair it would have been part of.
	function automatic count_beat_t apply_command(input stim_t s);
		count_beat_t r = '{count: '0, bad: 1'b0};
		logic [7:0]  b;
		bit          hit[N_POS];
		int          li[N_POS];
		int          p, q;
		case (s.op)
			CMD_CLEAR: begin
				foreach (letter_at_pos[i, j]) letter_at_pos[i][j] = '0;
				foreach (letter_pair[i, j]) letter_pair[i][j] = '0;
			end
			CMD_ADD: begin
				for (p = 0; p < N_POS; p++) begin
					// Positions past the end of the word field read as zero.
					b = (p < WORD_W / 8) ? s.word[p*8 +: 8] : 8'h00;
					hit[p] = (b >= ASCII_A) && (b <= ASCII_Z) &&
						(int'(b - ASCII_A) < N_LETTERS);
					li[p] = hit[p] ? int'(b - ASCII_A) : 0;
					if (hit[p])
						letter_at_pos[li[p]][p] = sat_inc(letter_at_pos[li[p]][p]);
				end
				// Every ordered pair of distinct positions, so a repeated
				// letter still pairs with itself once per direction.
				for (p = 0; p < N_POS; p++)
					for (q = 0; q < N_POS; q++)
						if (p != q && hit[p] && hit[q])
							letter_pair[li[p]][li[q]] = sat_inc(letter_pair[li[p]][li[q]]);
			end
			CMD_RD_POS: begin
				if (s.col >= N_POS)
					r.bad = 1'b1;
				else if (s.row < N_LETTERS)
					r.count = letter_at_pos[s.row][s.col];
			end
			default: begin
				if (s.row < N_LETTERS && s.col < N_LETTERS)
					r.count = letter_pair[s.row][s.col];
			end
		endcase
		return r;
	endfunction

	// Presents one command and holds it until the block takes it, which is
	// the first rising edge with start high and busy low. Start is left high
	// on return; the caller lowers it only if a gap follows.
	task automatic issue(input stim_t s);
		count_beat_t predicted;
		start      <= 1'b1;
		cmd        <= s.op;
		word       <= s.word;
		row_letter <= s.row;
		column     <= s.col;
		do @(posedge clk); while (busy !== 1'b0);
		predicted = apply_command(s);
		if (s.typed) begin
			predicted.count = s.exp_count;
			predicted.bad   = s.exp_bad;
		end
		awaited_counts.push_back(predicted);
		cmds_sent[s.op]++;
	endtask

	// Result checker. Done marks a beat that is valid for exactly one cycle,
	// so it is sampled at every rising edge and matched against the oldest
	// outstanding expectation.
	always @(posedge clk) begin
		count_beat_t want;
		if (arst_n && done === 1'b1) begin
			if (awaited_counts.size() == 0) begin
				flag_mismatch($sformatf("result beat with nothing outstanding, count %0d",
					count));
			end else begin
				want = awaited_counts.pop_front();
				beats_checked++;
				if (count !== want.count)
					flag_mismatch($sformatf("count %0d, expected %0d", count, want.count));
				if (bad_query !== want.bad)
					flag_mismatch($sformatf("bad_query %b, expected %b", bad_query,
						want.bad));
				if (count != '0)
					nonzero_reads++;
			end
		end
	end

	// Picks one word byte: mostly lowercase letters, crowded toward a..e so
	// that reads land on busy table entries, and now and then any byte at all.
	function automatic logic [7:0] pick_byte();
		int r = $urandom_range(0, 99);
		if (r < 40)
			return ASCII_A + 8'($urandom_range(0, 4));
		else if (r < 80)
			return ASCII_A + 8'($urandom_range(0, N_LETTERS - 1));
		return 8'($urandom_range(0, 255));
	endfunction

	// Letter index for a read: mostly a busy letter, sometimes any letter and
	// sometimes past the end of the alphabet.
	function automatic logic [FIELD_W-1:0] pick_letter();
		int r = $urandom_range(0, 99);
		if (r < 50)
			return FIELD_W'($urandom_range(0, 4));
		else if (r < 88)
			return FIELD_W'($urandom_range(0, N_LETTERS - 1));
		return FIELD_W'($urandom_range(0, 31));
	endfunction

	initial begin
		stim_t s;
		int    r, idle_left;
		bit    quiet;

		start      <= 1'b0;
		arst_n     <= 1'b0;
		cmd        <= CMD_CLEAR;
		word       <= '0;
		row_letter <= '0;
		column     <= '0;

		// Directed part. Reads straight after reset or a clear, out-of-range reads,
		// add results and clear results are typed in; reads of counts built
		// up by the adds are left to the shadow tables.
		plan.push_back(stim_t'{CMD_RD_POS,  40'h0, 5'd0,  5'd0,  1, 32'd0, 1'b0, 0});
		plan.push_back(stim_t'{CMD_RD_PAIR, 40'h0, 5'd25, 5'd25, 1, 32'd0, 1'b0, 0});
		// "aaaaa": five positional bumps and twenty (a,a) pairs.
		plan.push_back(stim_t'{CMD_ADD, 40'h61_61_61_61_61, 5'd0, 5'd0, 1, 32'd0, 1'b0, 0});
		// "zzzzz": the top letter at every position.
		plan.push_back(stim_t'{CMD_ADD, 40'h7a_7a_7a_7a_7a, 5'd0, 5'd0, 1, 32'd0, 1'b0, 0});
		// "`a{z@": the bytes just outside a to z sit between real letters.
		plan.push_back(stim_t'{CMD_ADD, 40'h40_7a_7b_61_60, 5'd0, 5'd0, 1, 32'd0, 1'b0, 0});
		// "AbCdE": uppercase letters are skipped.
		plan.push_back(stim_t'{CMD_ADD, 40'h45_64_43_62_41, 5'd0, 5'd0, 1, 32'd0, 1'b0, 0});
		plan.push_back(stim_t'{CMD_ADD, 40'h0,             5'd0, 5'd0, 1, 32'd0, 1'b0, 0});
		plan.push_back(stim_t'{CMD_ADD, '1,                5'd31, 5'd31, 1, 32'd0, 1'b0, 0});
		plan.push_back(stim_t'{CMD_RD_POS,  40'h0, 5'd0,  5'd0,  0, 32'd0, 1'b0, 0});
		plan.push_back(stim_t'{CMD_RD_POS,  40'h0, 5'd25, 5'd4,  0, 32'd0, 1'b0, 0});
		plan.push_back(stim_t'{CMD_RD_POS,  40'h0, 5'd0,  5'd3,  0, 32'd0, 1'b0, 0});
		plan.push_back(stim_t'{CMD_RD_POS,  40'h0, 5'd1,  5'd1,  0, 32'd0, 1'b0, 0});
		plan.push_back(stim_t'{CMD_RD_PAIR, 40'h0, 5'd0,  5'd0,  0, 32'd0, 1'b0, 0});
		plan.push_back(stim_t'{CMD_RD_PAIR, 40'h0, 5'd25, 5'd25, 0, 32'd0, 1'b0, 0});
		plan.push_back(stim_t'{CMD_RD_PAIR, 40'h0, 5'd0,  5'd25, 0, 32'd0, 1'b0, 0});
		// Out-of-range reads: column past the word, letter past the alphabet.
		plan.push_back(stim_t'{CMD_RD_POS,  40'h0, 5'd0,  5'd5,  1, 32'd0, 1'b1, 0});
		plan.push_back(stim_t'{CMD_RD_POS,  40'h0, 5'd31, 5'd31, 1, 32'd0, 1'b1, 0});
		plan.push_back(stim_t'{CMD_RD_POS,  40'h0, 5'd26, 5'd0,  1, 32'd0, 1'b0, 0});
		plan.push_back(stim_t'{CMD_RD_PAIR, 40'h0, 5'd31, 5'd0,  1, 32'd0, 1'b0, 0});
		plan.push_back(stim_t'{CMD_RD_PAIR, 40'h0, 5'd0,  5'd26, 1, 32'd0, 1'b0, 0});
		// Clear with the pipe drained first, then prove both tables are empty.
		plan.push_back(stim_t'{CMD_CLEAR,   40'h0, 5'd0,  5'd0,  1, 32'd0, 1'b0, 1});
		plan.push_back(stim_t'{CMD_RD_POS,  40'h0, 5'd0,  5'd0,  1, 32'd0, 1'b0, 0});
		plan.push_back(stim_t'{CMD_RD_PAIR, 40'h0, 5'd0,  5'd0,  1, 32'd0, 1'b0, 0});
		// "hello": the repeated l gives (l,l) twice.
		plan.push_back(stim_t'{CMD_ADD, 40'h6f_6c_6c_65_68, 5'd0, 5'd0, 1, 32'd0, 1'b0, 0});
		plan.push_back(stim_t'{CMD_RD_PAIR, 40'h0, 5'd11, 5'd11, 0, 32'd0, 1'b0, 0});

		// Random part. Clears are rare since each one sweeps the whole table;
		// adds and reads share the rest so that counts grow and get read back.
		for (int i = 0; i < N_RANDOM; i++) begin
			s = '{op: CMD_ADD, word: '0, row: '0, col: '0, typed: 0,
				exp_count: '0, exp_bad: 1'b0, drain: (i % 250 == 249)};
			r = $urandom_range(0, 99);
			if (r < 1)
				s.op = CMD_CLEAR;
			else if (r < 46)
				s.op = CMD_ADD;
			else if (r < 73)
				s.op = CMD_RD_POS;
			else
				s.op = CMD_RD_PAIR;
			for (int p = 0; p < WORD_W / 8; p++)
				s.word[p*8 +: 8] = pick_byte();
			s.row = pick_letter();
			if (s.op == CMD_RD_POS)
				s.col = ($urandom_range(0, 99) < 85) ? FIELD_W'($urandom_range(0, N_POS - 1))
					: FIELD_W'($urandom_range(0, 31));
			else
				s.col = pick_letter();
			plan.push_back(s);
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Walk the plan. Between beats the sender sometimes drops start for a
		// random stretch, long enough at times to outlast an add, so gaps land
		// both while the block is busy and while it sits idle. A window in the
		// middle of the random part runs back to back with no random gaps.
		for (int i = 0; i < plan.size(); i++) begin
			quiet = (i >= QUIET_LO) && (i < QUIET_HI);
			if (plan[i].drain) begin
				start <= 1'b0;
				do @(posedge clk); while (awaited_counts.size() != 0);
			end else if (!quiet && $urandom_range(0, 99) < 33) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 30)) @(posedge clk);
			end
			issue(plan[i]);
		end
		start <= 1'b0;

		// Let the last results come home, then give the block a few more
		// cycles to show any stray beat.
		idle_left = DRAIN_LIM;
		while (awaited_counts.size() != 0 && idle_left > 0) begin
			@(posedge clk);
			idle_left--;
		end
		repeat (TAIL_WAIT) @(posedge clk);
		if (awaited_counts.size() != 0)
			flag_mismatch($sformatf("%0d results never arrived", awaited_counts.size()));

		$display("sent %0d commands: %0d clears, %0d adds, %0d positional reads, %0d pair reads",
			plan.size(), cmds_sent[CMD_CLEAR], cmds_sent[CMD_ADD], cmds_sent[CMD_RD_POS],
			cmds_sent[CMD_RD_PAIR]);
		$display("checked %0d result beats, %0d of them with a nonzero count",
			beats_checked, nonzero_reads);
		if (mismatches == 0)
			$display("letter_position_and_pair_histogram regression: pass");
		else
			$display("letter_position_and_pair_histogram regression: fail");
		$finish;
	end

	// Watchdog: well beyond a run in which every command is a full clear.
	initial begin
		#(64'd20 * 64'd6_000_000);
		$display("letter_position_and_pair_histogram regression: fail");
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/lph_pkg.sv
sv/lph_ram.sv
sv/lph_table.sv
sv/letter_position_and_pair_histogram.sv
verif/tb_letter_position_and_pair_histogram.sv
